// ===== rtl/ttw_pkg.sv =====
// Shared types and codes for the text terminal writer.
package ttw_pkg;

  // Codes of the kind field of a command word.
  localparam logic [1:0] KIND_PUT   = 2'd0;
  localparam logic [1:0] KIND_CLEAR = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  // Control bytes recognized by a put command.
  localparam logic [7:0] NEWLINE_CODE = 8'd10;
  localparam logic [7:0] RETURN_CODE  = 8'd13;

  // Operations handed from the front end to the execution unit.
  typedef enum logic [2:0] {
    OP_PRINT,
    OP_NEWLINE,
    OP_RETURN,
    OP_CLEAR,
    OP_READ,
    OP_NOP
  } op_t;

  // Command word as it arrives on the input channel.
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  char_code;
    logic [7:0]  color;
    logic [10:0] read_index;
  } cmd_word_t;

  // Response word as it leaves on the output channel.
  typedef struct packed {
    logic [15:0] cell_data;
    logic [4:0]  cursor_row;
    logic [6:0]  cursor_column;
  } rsp_word_t;

  // Decoded operation held in the queue between front and back.
  typedef struct packed {
    op_t         op;
    logic [7:0]  char_code;
    logic [7:0]  color;
    logic [10:0] read_index;
  } task_t;

endpackage

// ===== rtl/ttw_front.sv =====
// Front end: accepts command words, decodes them and queues them for execution.
module ttw_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_stall,
  input  ttw_pkg::cmd_word_t cmd,
  input  logic              accept_en,
  output logic              head_valid,
  output ttw_pkg::task_t    head,
  input  logic              pop
);
  import ttw_pkg::*;

  task_t       slots [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        push;
  task_t       decoded;

  // Decode the command word into an operation.
  always_comb begin
    decoded.char_code  = cmd.char_code;
    decoded.color      = cmd.color;
    decoded.read_index = cmd.read_index;
    case (cmd.kind)
      KIND_PUT: begin
        if (cmd.char_code == NEWLINE_CODE) begin
          decoded.op = OP_NEWLINE;
        end else if (cmd.char_code == RETURN_CODE) begin
          decoded.op = OP_RETURN;
        end else begin
          decoded.op = OP_PRINT;
        end
      end
      KIND_CLEAR: decoded.op = OP_CLEAR;
      KIND_READ:  decoded.op = OP_READ;
      default:    decoded.op = OP_NOP;
    endcase
  end

  // The queue takes a word while it has room and the store is initialized.
  assign cmd_stall  = (count == 2'd2) || !accept_en;
  assign push       = cmd_valid && !cmd_stall;
  assign head_valid = (count != 2'd0);
  assign head       = slots[rd_ptr];

  // Two-entry queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= decoded;
    end
  end

  // Queue pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ===== rtl/ttw_back.sv =====
// Execution unit: cursor, cell store, scroll and clear sequencer, response register.
module ttw_back #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               head_valid,
  input  ttw_pkg::task_t     head,
  output logic               pop,
  output logic               accept_en,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output ttw_pkg::rsp_word_t rsp
);
  import ttw_pkg::*;

  localparam int CELLS     = COLUMNS * ROWS;
  localparam int LAST_BODY = CELLS - COLUMNS;
  localparam int ADDR_W    = $clog2(CELLS);
  localparam int ROW_W     = $clog2(ROWS);
  localparam int COL_W     = $clog2(COLUMNS);

  typedef enum logic [2:0] {
    S_WIPE,
    S_IDLE,
    S_READ,
    S_COPY,
    S_FLUSH
  } state_t;

  state_t             state;
  logic [ADDR_W-1:0]  ptr;
  logic [ROW_W-1:0]   row;
  logic [COL_W-1:0]   col;
  logic               res_valid;
  rsp_word_t          res;
  logic               wipe_reply;
  logic               init_done;
  logic               rd_ok;
  logic               wq_valid;
  logic               wq_zero;
  logic [ADDR_W-1:0]  wq_addr;
  logic [15:0]        store [CELLS];
  logic [15:0]        rdata;
  logic               we;
  logic [ADDR_W-1:0]  waddr;
  logic [15:0]        wdata;
  logic [ADDR_W-1:0]  raddr;
  logic [ADDR_W-1:0]  cur_addr;
  logic [ROW_W-1:0]   row_inc;
  logic [COL_W-1:0]   col_inc;
  logic               at_line_end;
  logic               at_bottom;
  logic               start;

  // Pack a response word, masking the cursor to the field widths.
  function automatic rsp_word_t pack_rsp(logic [15:0] data, logic [ROW_W-1:0] r,
                                         logic [COL_W-1:0] c);
    logic [31:0] r32;
    logic [31:0] c32;
    rsp_word_t   w;
    r32             = 32'(r);
    c32             = 32'(c);
    w.cell_data     = data;
    w.cursor_row    = r32[4:0];
    w.cursor_column = c32[6:0];
    return w;
  endfunction

  // Cursor arithmetic.
  assign cur_addr    = ADDR_W'(32'(row) * COLUMNS + 32'(col));
  assign row_inc     = row + 1'b1;
  assign col_inc     = col + 1'b1;
  assign at_line_end = (col == COL_W'(COLUMNS - 1));
  assign at_bottom   = (row == ROW_W'(ROWS - 1));

  // A new operation starts when idle and the response register is free.
  assign start     = (state == S_IDLE) && head_valid && !res_valid;
  assign pop       = start;
  assign accept_en = init_done;
  assign rsp_valid = res_valid;
  assign rsp       = res;

  // Store port control.
  always_comb begin
    we    = 1'b0;
    waddr = ptr;
    wdata = '0;
    raddr = ptr + ADDR_W'(COLUMNS);
    case (state)
      S_WIPE: begin
        we = 1'b1;
      end
      S_IDLE: begin
        if (start && head.op == OP_PRINT) begin
          we    = 1'b1;
          waddr = cur_addr;
          wdata = {head.color, head.char_code};
        end
        if (start && head.op == OP_READ) begin
          raddr = ADDR_W'(32'(head.read_index));
        end
      end
      default: begin
      end
    endcase
    // Delayed write of the scroll copy stream.
    if (wq_valid) begin
      we    = 1'b1;
      waddr = wq_addr;
      wdata = wq_zero ? 16'd0 : rdata;
    end
  end

  // Cell store with registered read data.
  always_ff @(posedge clk) begin
    if (we) begin
      store[waddr] <= wdata;
    end
    rdata <= store[raddr];
  end

  // Sequencer, cursor and response register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_WIPE;
      ptr        <= '0;
      row        <= '0;
      col        <= '0;
      res_valid  <= 1'b0;
      wq_valid   <= 1'b0;
      wipe_reply <= 1'b0;
      init_done  <= 1'b0;
    end else begin
      if (res_valid && !rsp_stall) begin
        res_valid <= 1'b0;
      end
      wq_valid <= 1'b0;
      case (state)
        S_WIPE: begin
          ptr <= ptr + 1'b1;
          if (ptr == ADDR_W'(CELLS - 1)) begin
            ptr       <= '0;
            state     <= S_IDLE;
            init_done <= 1'b1;
            if (wipe_reply) begin
              res       <= pack_rsp(16'd0, row, col);
              res_valid <= 1'b1;
            end
          end
        end
        S_IDLE: begin
          if (start) begin
            case (head.op)
              OP_PRINT: begin
                if (!at_line_end) begin
                  col       <= col_inc;
                  res       <= pack_rsp(16'd0, row, col_inc);
                  res_valid <= 1'b1;
                end else if (!at_bottom) begin
                  col       <= '0;
                  row       <= row_inc;
                  res       <= pack_rsp(16'd0, row_inc, '0);
                  res_valid <= 1'b1;
                end else begin
                  col   <= '0;
                  state <= S_COPY;
                end
              end
              OP_NEWLINE: begin
                if (at_bottom) begin
                  state <= S_COPY;
                end else begin
                  row       <= row_inc;
                  res       <= pack_rsp(16'd0, row_inc, col);
                  res_valid <= 1'b1;
                end
              end
              OP_RETURN: begin
                col       <= '0;
                res       <= pack_rsp(16'd0, row, '0);
                res_valid <= 1'b1;
              end
              OP_CLEAR: begin
                row        <= '0;
                col        <= '0;
                wipe_reply <= 1'b1;
                state      <= S_WIPE;
              end
              OP_READ: begin
                rd_ok <= (32'(head.read_index) < CELLS);
                state <= S_READ;
              end
              default: begin
                res       <= pack_rsp(16'd0, row, col);
                res_valid <= 1'b1;
              end
            endcase
          end
        end
        S_READ: begin
          res       <= pack_rsp(rd_ok ? rdata : 16'd0, row, col);
          res_valid <= 1'b1;
          state     <= S_IDLE;
        end
        S_COPY: begin
          // Read the cell one line below now, write it in the following cycle.
          wq_valid <= 1'b1;
          wq_addr  <= ptr;
          wq_zero  <= (32'(ptr) >= LAST_BODY);
          ptr      <= ptr + 1'b1;
          if (ptr == ADDR_W'(CELLS - 1)) begin
            ptr   <= '0;
            state <= S_FLUSH;
          end
        end
        S_FLUSH: begin
          res       <= pack_rsp(16'd0, row, col);
          res_valid <= 1'b1;
          state     <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_cursor_in_screen: assert property (@(posedge clk) disable iff (rst)
    (row <= ROW_W'(ROWS - 1)) && (col <= COL_W'(COLUMNS - 1)))
    else $error("cursor left the screen");
  a_flush_posts: assert property (@(posedge clk) disable iff (rst)
    (state == S_FLUSH) |=> res_valid)
    else $error("scroll finished without a response");
  a_copy_write_window: assert property (@(posedge clk) disable iff (rst)
    wq_valid |-> (state == S_COPY || state == S_FLUSH))
    else $error("scroll write outside the scroll sequence");
  a_reset_wipes: assert property (@(posedge clk)
    rst |=> (state == S_WIPE && !init_done))
    else $error("reset did not start the clearing pass");
`endif

endmodule

// ===== rtl/text_terminal_writer_core.sv =====
// Top level of the text terminal writer: command queue front end and execution unit.
// A newline or wrap on the bottom row scrolls, one cell copied per cycle.
// A clear command zeroes one cell per cycle by the store port.
// A new word starts only once the last response has been taken; the single write port of the store sets the walks.
// Reset clears the cursor and runs a clearing pass over every cell with the input stalled.
module text_terminal_writer_core #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_stall,
  input  ttw_pkg::cmd_word_t cmd,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output ttw_pkg::rsp_word_t rsp
);
  import ttw_pkg::*;

  logic  head_valid;
  task_t head;
  logic  pop;
  logic  accept_en;

  // Decode and queue incoming words.
  ttw_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd_stall  (cmd_stall),
    .cmd        (cmd),
    .accept_en  (accept_en),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  // Carry out queued operations against the cell store.
  ttw_back #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .accept_en  (accept_en),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .rsp        (rsp)
  );

endmodule
